// ===== hdl/srp_pkg.sv =====
// Package for the scheduling request block: command and register codes,
// field widths and register reset values. Depends on nothing.
package srp_pkg;

    localparam int unsigned TTI_W      = 14;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned PERIOD_W   = 8;
    localparam int unsigned PROHIBIT_W = 10;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CFG_IDX_W  = 2;

    // TTI numbering wraps at this value.
    localparam logic [TTI_W-1:0] TTI_WRAP = 14'd10240;

    // Configuration register values after reset.
    localparam logic                  SR_ENABLE_RST       = 1'b0;
    localparam logic [COUNT_W-1:0]    MAX_ATTEMPTS_RST    = 7'd4;
    localparam logic [PERIOD_W-1:0]   SEND_PERIOD_RST     = 8'd10;
    localparam logic [PROHIBIT_W-1:0] PROHIBIT_LENGTH_RST = 10'd0;

    typedef enum logic [1:0] {
        CMD_STEP    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_GRANT   = 2'd2,
        CMD_RESET   = 2'd3
    } command_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SR_ENABLE       = 2'd0,
        REG_MAX_ATTEMPTS    = 2'd1,
        REG_SEND_PERIOD     = 2'd2,
        REG_PROHIBIT_LENGTH = 2'd3
    } cfg_index_t;

endpackage

// ===== hdl/scheduling_request_procedure.sv =====
// Scheduling request state machine of a user equipment, one event word per clock.
// Depends on srp_pkg for command codes, register indexes, widths and reset values.
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+------------------------------------------
//  event in  | cmd_valid / cmd_ready           | command, tti_now
//  result    | res_valid / res_ready           | sent_now, failed_now, succeeded_now,
//            |                                 | is_pending, attempts_made
//  config    | cfg_write_en (no wait)          | cfg_index, cfg_data
//
// Each event word is decoded against the procedure state in the cycle it is
// accepted; the new state and the result word are registered at that edge, and
// one word can be accepted every cycle. cmd_ready is high whenever the result
// register is empty or is being drained in the same cycle, so the only stall is
// a result word that the consumer has not taken. Reset (rst_n low, asynchronous)
// empties the result register, returns the procedure to idle and loads the
// configuration registers with their defaults.
module scheduling_request_procedure
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [1:0]                        command,
    input  logic [srp_pkg::TTI_W-1:0]         tti_now,

    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              sent_now,
    output logic                              failed_now,
    output logic                              succeeded_now,
    output logic                              is_pending,
    output logic [srp_pkg::COUNT_W-1:0]       attempts_made,

    input  logic                              cfg_write_en,
    input  logic [srp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    logic                                sr_enable_reg;
    logic [srp_pkg::COUNT_W-1:0]         max_attempts_reg;
    logic [srp_pkg::PERIOD_W-1:0]        send_period_reg;
    logic [srp_pkg::PROHIBIT_W-1:0]      prohibit_length_reg;

    // Procedure state.
    logic                                pending_reg,       pending_next;
    logic [srp_pkg::COUNT_W-1:0]         attempt_reg,       attempt_next;
    logic [srp_pkg::TTI_W-1:0]           last_tti_reg,      last_tti_next;
    logic                                ever_sent_reg,     ever_sent_next;
    logic [srp_pkg::PROHIBIT_W-1:0]      prohibit_reg,      prohibit_next;

    // Result register.
    logic                                res_valid_reg;
    logic                                sent_reg,          sent_next;
    logic                                failed_reg,        failed_next;
    logic                                ok_reg,            ok_next;

    logic                                accept;
    logic                                usable;
    logic                                period_passed;
    logic [srp_pkg::TTI_W-1:0]           back_gap;
    logic [srp_pkg::TTI_W-1:0]           gap;
    logic [srp_pkg::PROHIBIT_W-1:0]      prohibit_dec;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;

    // A set enable with a zero attempt limit counts as no resource at all.
    assign usable = sr_enable_reg && (max_attempts_reg != '0);

    // Interval since the last send. When the TTI has wrapped, the interval is
    // the wrap length less the backward distance; a backward distance beyond
    // the wrap length can only come from out-of-range TTIs and counts as passed.
    assign back_gap = last_tti_reg - tti_now;
    assign gap      = (tti_now >= last_tti_reg) ? (tti_now - last_tti_reg)
                                                : (srp_pkg::TTI_WRAP - back_gap);

    always_comb
    begin
        priority if (!ever_sent_reg)
        begin
            period_passed = 1'b1;
        end
        else if (tti_now < last_tti_reg && back_gap > srp_pkg::TTI_WRAP)
        begin
            period_passed = 1'b1;
        end
        else
        begin
            period_passed = (gap >= {{(srp_pkg::TTI_W - srp_pkg::PERIOD_W){1'b0}},
                                     send_period_reg});
        end
    end

    // The prohibit timer counts down first on every step of a pending request.
    assign prohibit_dec = (prohibit_reg != '0) ? (prohibit_reg - 1'b1) : prohibit_reg;

    always_comb
    begin
        pending_next   = pending_reg;
        attempt_next   = attempt_reg;
        last_tti_next  = last_tti_reg;
        ever_sent_next = ever_sent_reg;
        prohibit_next  = prohibit_reg;
        sent_next      = 1'b0;
        failed_next    = 1'b0;
        ok_next        = 1'b0;

        unique case (srp_pkg::command_t'(command))
            srp_pkg::CMD_STEP:
            begin
                if (pending_reg)
                begin
                    prohibit_next = prohibit_dec;
                    if (usable)
                    begin
                        if (attempt_reg < max_attempts_reg)
                        begin
                            if (prohibit_dec == '0 &&
                                (attempt_reg == '0 || period_passed))
                            begin
                                attempt_next   = attempt_reg + 1'b1;
                                last_tti_next  = tti_now;
                                ever_sent_next = 1'b1;
                                prohibit_next  = prohibit_length_reg;
                                sent_next      = 1'b1;
                            end
                        end
                        else if (period_passed)
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end

                    if (failed_next)
                    begin
                        pending_next = 1'b0;
                        attempt_next = '0;
                    end
                end
            end

            srp_pkg::CMD_TRIGGER:
            begin
                // A trigger while already pending does not restart the count.
                if (usable && !pending_reg)
                begin
                    pending_next = 1'b1;
                    attempt_next = '0;
                end
            end

            srp_pkg::CMD_GRANT:
            begin
                if (pending_reg)
                begin
                    ok_next       = (attempt_reg != '0);
                    pending_next  = 1'b0;
                    attempt_next  = '0;
                    prohibit_next = '0;
                end
            end

            srp_pkg::CMD_RESET:
            begin
                // The last send TTI and the sent flag survive a reset command.
                pending_next  = 1'b0;
                attempt_next  = '0;
                prohibit_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_enable_reg       <= srp_pkg::SR_ENABLE_RST;
            max_attempts_reg    <= srp_pkg::MAX_ATTEMPTS_RST;
            send_period_reg     <= srp_pkg::SEND_PERIOD_RST;
            prohibit_length_reg <= srp_pkg::PROHIBIT_LENGTH_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (srp_pkg::cfg_index_t'(cfg_index))
                srp_pkg::REG_SR_ENABLE:
                    sr_enable_reg <= cfg_data[0];
                srp_pkg::REG_MAX_ATTEMPTS:
                    max_attempts_reg <= cfg_data[srp_pkg::COUNT_W-1:0];
                srp_pkg::REG_SEND_PERIOD:
                    send_period_reg <= cfg_data[srp_pkg::PERIOD_W-1:0];
                srp_pkg::REG_PROHIBIT_LENGTH:
                    prohibit_length_reg <= cfg_data[srp_pkg::PROHIBIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            attempt_reg   <= '0;
            last_tti_reg  <= '0;
            ever_sent_reg <= 1'b0;
            prohibit_reg  <= '0;
        end
        else if (accept)
        begin
            pending_reg   <= pending_next;
            attempt_reg   <= attempt_next;
            last_tti_reg  <= last_tti_next;
            ever_sent_reg <= ever_sent_next;
            prohibit_reg  <= prohibit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload; the pending flag and count are read from the state
    // registers, which hold the values left by the word in the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sent_reg   <= sent_next;
            failed_reg <= failed_next;
            ok_reg     <= ok_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign sent_now      = sent_reg;
    assign failed_now    = failed_reg;
    assign succeeded_now = ok_reg;
    assign is_pending    = pending_reg;
    assign attempts_made = attempt_reg;

endmodule

// ===== tb/sv/tb_scheduling_request_procedure.sv =====
// Self-checking testbench for the scheduling request block: directed and random event words
// are checked against a behavioural predictor held in a small scoreboard class.
// Depends on srp_pkg and on the scheduling_request_procedure RTL.

typedef struct packed {
    logic                        sent;
    logic                        failed;
    logic                        succeeded;
    logic                        pending;
    logic [srp_pkg::COUNT_W-1:0] attempts;
} sr_outcome_t;

class sr_scoreboard;

    logic                           sr_enable;
    logic [srp_pkg::COUNT_W-1:0]    max_attempts;
    logic [srp_pkg::PERIOD_W-1:0]   send_period;
    logic [srp_pkg::PROHIBIT_W-1:0] prohibit_length;

    bit                             pending;
    logic [srp_pkg::COUNT_W-1:0]    attempt_count;
    logic [srp_pkg::TTI_W-1:0]      last_send_tti;
    bit                             ever_sent;
    logic [srp_pkg::PROHIBIT_W-1:0] prohibit_left;

    sr_outcome_t                    outcomes_due[$];
    int unsigned                    mismatches;
    int unsigned                    results_seen;

    function new();
        sr_enable       = srp_pkg::SR_ENABLE_RST;
        max_attempts    = srp_pkg::MAX_ATTEMPTS_RST;
        send_period     = srp_pkg::SEND_PERIOD_RST;
        prohibit_length = srp_pkg::PROHIBIT_LENGTH_RST;
        pending         = 1'b0;
        attempt_count   = '0;
        last_send_tti   = '0;
        ever_sent       = 1'b0;
        prohibit_left   = '0;
        mismatches      = 0;
        results_seen    = 0;
    endfunction

    function void write_register(srp_pkg::cfg_index_t idx,
                                 logic [srp_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            srp_pkg::REG_SR_ENABLE:       sr_enable       = value[0];
            srp_pkg::REG_MAX_ATTEMPTS:    max_attempts    = value[srp_pkg::COUNT_W-1:0];
            srp_pkg::REG_SEND_PERIOD:     send_period     = value[srp_pkg::PERIOD_W-1:0];
            srp_pkg::REG_PROHIBIT_LENGTH: prohibit_length = value[srp_pkg::PROHIBIT_W-1:0];
            default: ;
        endcase
    endfunction

    function bit resource_usable();
        return sr_enable && (max_attempts != '0);
    endfunction

    // The interval wraps at the TTI frame limit; a negative interval can only
    // come from TTI numbers beyond the limit and then counts as elapsed.
    function bit period_elapsed(logic [srp_pkg::TTI_W-1:0] tti);
        int gap;
        if (!ever_sent)
            return 1'b1;
        if (tti >= last_send_tti)
            gap = int'(tti) - int'(last_send_tti);
        else
            gap = int'(srp_pkg::TTI_WRAP) + int'(tti) - int'(last_send_tti);
        if (gap < 0)
            return 1'b1;
        return gap >= int'(send_period);
    endfunction

    // Applies one accepted event word to the procedure state and queues the
    // result word the block must return for it.
    function void note_event(srp_pkg::command_t cmd, logic [srp_pkg::TTI_W-1:0] tti);
        sr_outcome_t due;
        due = '0;
        case (cmd)
            srp_pkg::CMD_STEP:
            begin
                if (pending)
                begin
                    if (prohibit_left != '0)
                        prohibit_left = prohibit_left - 1'b1;
                    if (resource_usable())
                    begin
                        if (attempt_count < max_attempts)
                        begin
                            if (prohibit_left == '0 &&
                                (attempt_count == '0 || period_elapsed(tti)))
                            begin
                                attempt_count = attempt_count + 1'b1;
                                last_send_tti = tti;
                                ever_sent     = 1'b1;
                                prohibit_left = prohibit_length;
                                due.sent      = 1'b1;
                            end
                        end
                        else if (period_elapsed(tti))
                            due.failed = 1'b1;
                    end
                    else
                        due.failed = 1'b1;
                    if (due.failed)
                    begin
                        pending       = 1'b0;
                        attempt_count = '0;
                    end
                end
            end
            srp_pkg::CMD_TRIGGER:
            begin
                if (resource_usable() && !pending)
                begin
                    attempt_count = '0;
                    pending       = 1'b1;
                end
            end
            srp_pkg::CMD_GRANT:
            begin
                if (pending)
                begin
                    due.succeeded = (attempt_count != '0);
                    pending       = 1'b0;
                    attempt_count = '0;
                    prohibit_left = '0;
                end
            end
            default:
            begin
                pending       = 1'b0;
                attempt_count = '0;
                prohibit_left = '0;
            end
        endcase
        due.pending  = pending;
        due.attempts = attempt_count;
        outcomes_due.push_back(due);
    endfunction

    function void check_outcome(sr_outcome_t got);
        sr_outcome_t want;
        bit          bad;
        results_seen++;
        if (outcomes_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with no event word outstanding", results_seen);
            return;
        end
        want = outcomes_due.pop_front();
        bad  = (got.sent !== want.sent) || (got.failed !== want.failed) ||
               (got.succeeded !== want.succeeded) || (got.pending !== want.pending) ||
               (got.attempts !== want.attempts);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result %0d: expected sent=%0b failed=%0b ok=%0b pend=%0b cnt=%0d",
                         results_seen, want.sent, want.failed, want.succeeded,
                         want.pending, want.attempts);
                $display("result %0d: got      sent=%0b failed=%0b ok=%0b pend=%0b cnt=%0d",
                         results_seen, got.sent, got.failed, got.succeeded,
                         got.pending, got.attempts);
            end
        end
    endfunction

endclass

module tb_scheduling_request_procedure;

    // Cycles without a single handshake on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cmd_valid     = 1'b0;
    logic                           cmd_ready;
    logic [1:0]                     command       = srp_pkg::CMD_STEP;
    logic [srp_pkg::TTI_W-1:0]      tti_now       = '0;
    logic                           res_valid;
    logic                           res_ready     = 1'b0;
    logic                           sent_now;
    logic                           failed_now;
    logic                           succeeded_now;
    logic                           is_pending;
    logic [srp_pkg::COUNT_W-1:0]    attempts_made;
    logic                           cfg_write_en  = 1'b0;
    logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index     = srp_pkg::REG_SR_ENABLE;
    logic [srp_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    // Set for the final phase, in which neither side idles or stalls.
    bit                             quiet_tail    = 1'b0;
    int                             ready_hold    = 0;
    int                             stalled_cycles = 0;
    // Running TTI clock used to build well-formed step sequences.
    int                             tti_clock     = 0;

    sr_scoreboard sb = new();

    scheduling_request_procedure dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command       (command),
        .tti_now       (tti_now),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .sent_now      (sent_now),
        .failed_now    (failed_now),
        .succeeded_now (succeeded_now),
        .is_pending    (is_pending),
        .attempts_made (attempts_made),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Result side. Every value read here is the one held before this edge, as
    // all drivers, the block's included, update through nonblocking assignments.
    // The result word is checked when it is taken, then res_ready is chosen for
    // the next edge: occasional stalls, none in the tail.
    always @(posedge clk)
    begin : collect_results
        sr_outcome_t seen;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                seen.sent      = sent_now;
                seen.failed    = failed_now;
                seen.succeeded = succeeded_now;
                seen.pending   = is_pending;
                seen.attempts  = attempts_made;
                sb.check_outcome(seen);
            end
            if (quiet_tail)
                res_ready <= 1'b1;
            else if (ready_hold > 0)
            begin
                res_ready  <= 1'b0;
                ready_hold <= ready_hold - 1;
            end
            else if ($urandom_range(0, 99) < 12)
            begin
                res_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 8);
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Watchdog: counts edges at which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
            stalled_cycles <= 0;
        else if (stalled_cycles < STALL_LIMIT)
            stalled_cycles <= stalled_cycles + 1;
        else
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one event word and holds it until the block takes it. The task is
    // always entered just after a rising edge, so valid is seen high at the next
    // one. The scoreboard is told of the word at the edge that accepts it; its
    // result cannot be taken before the following edge, so the expectation is
    // always queued first. An idle gap, when one is drawn, lowers valid once.
    task automatic push_event(input srp_pkg::command_t cmd,
                              input logic [srp_pkg::TTI_W-1:0] tti);
        int gap;
        command   <= cmd;
        tti_now   <= tti;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note_event(cmd, tti);
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 99) < 15)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering words and waits until every result word has come back.
    // Each word yields exactly one result, so the block is then idle.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.outcomes_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes all four registers back to back, only once the block is idle.
    task automatic load_registers(input logic enable, input int unsigned attempts,
                                  input int unsigned period, input int unsigned prohibit);
        srp_pkg::cfg_index_t            idx[4];
        logic [srp_pkg::CFG_DATA_W-1:0] val[4];
        drain();
        idx[0] = srp_pkg::REG_SR_ENABLE;       val[0] = srp_pkg::CFG_DATA_W'(enable);
        idx[1] = srp_pkg::REG_MAX_ATTEMPTS;    val[1] = srp_pkg::CFG_DATA_W'(attempts);
        idx[2] = srp_pkg::REG_SEND_PERIOD;     val[2] = srp_pkg::CFG_DATA_W'(period);
        idx[3] = srp_pkg::REG_PROHIBIT_LENGTH; val[3] = srp_pkg::CFG_DATA_W'(prohibit);
        for (int i = 0; i < 4; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= idx[i];
            cfg_data     <= val[i];
            sb.write_register(idx[i], val[i]);
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
    endtask

    // A random phase made mostly of well-formed procedures: a trigger, then a
    // run of steps on consecutive TTIs, ended by a grant, a reset command or a
    // failure. Jumps in the TTI clock, TTIs beyond the frame limit and random
    // commands are mixed in as noise.
    task automatic run_phase(input int words, input int grant_pct);
        srp_pkg::command_t         cmd;
        logic [srp_pkg::TTI_W-1:0] tti;
        int                        roll;
        for (int n = 0; n < words; n++)
        begin
            roll = $urandom_range(0, 99);
            if (!sb.pending)
            begin
                if (roll < 60)
                    cmd = srp_pkg::CMD_TRIGGER;
                else
                    cmd = srp_pkg::command_t'(2'($urandom_range(0, 3)));
            end
            else if (roll < grant_pct)
                cmd = srp_pkg::CMD_GRANT;
            else if (roll < grant_pct + 2)
                cmd = srp_pkg::CMD_RESET;
            else if (roll < grant_pct + 5)
                cmd = srp_pkg::CMD_TRIGGER;
            else
                cmd = srp_pkg::CMD_STEP;

            roll = $urandom_range(0, 99);
            if (cmd != srp_pkg::CMD_STEP)
                tti = srp_pkg::TTI_W'($urandom_range(0, 16383));
            else if (roll < 90)
            begin
                tti_clock = (tti_clock + 1) % int'(srp_pkg::TTI_WRAP);
                tti       = srp_pkg::TTI_W'(tti_clock);
            end
            else if (roll < 95)
            begin
                tti_clock = (tti_clock + $urandom_range(2, 300)) % int'(srp_pkg::TTI_WRAP);
                tti       = srp_pkg::TTI_W'(tti_clock);
            end
            else
            begin
                tti       = srp_pkg::TTI_W'($urandom_range(0, 16383));
                tti_clock = int'(tti) % int'(srp_pkg::TTI_WRAP);
            end
            push_event(cmd, tti);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults leave the resource disabled: an idle step at the
        // last TTI of the frame, a trigger that must be ignored, a grant while
        // idle and a reset command.
        push_event(srp_pkg::CMD_STEP, 14'd10239);
        push_event(srp_pkg::CMD_TRIGGER, 14'd0);
        push_event(srp_pkg::CMD_GRANT, 14'd0);
        push_event(srp_pkg::CMD_RESET, 14'd0);

        // Two attempts, a period of three and a prohibit of two: the second
        // trigger is ignored, the timer holds off the resend, and once both
        // attempts are spent the procedure fails when the period runs out.
        load_registers(1'b1, 2, 3, 2);
        push_event(srp_pkg::CMD_TRIGGER, 14'd0);
        push_event(srp_pkg::CMD_TRIGGER, 14'd0);
        for (int t = 100; t <= 106; t++)
            push_event(srp_pkg::CMD_STEP, srp_pkg::TTI_W'(t));

        // A procedure spanning the frame wrap, ended by a grant after a send.
        push_event(srp_pkg::CMD_TRIGGER, 14'd0);
        push_event(srp_pkg::CMD_STEP, 14'd10238);
        push_event(srp_pkg::CMD_STEP, 14'd0);
        push_event(srp_pkg::CMD_STEP, 14'd1);
        push_event(srp_pkg::CMD_GRANT, 14'd0);

        // A send at a TTI beyond the frame limit makes the next interval
        // negative, which counts as elapsed once the timer has run out; then
        // a reset command.
        push_event(srp_pkg::CMD_TRIGGER, 14'd0);
        push_event(srp_pkg::CMD_STEP, 14'd16383);
        push_event(srp_pkg::CMD_STEP, 14'd5);
        push_event(srp_pkg::CMD_STEP, 14'd6);
        push_event(srp_pkg::CMD_RESET, 14'd0);

        // Enabled with zero attempts counts as disabled.
        load_registers(1'b1, 0, 10, 0);
        push_event(srp_pkg::CMD_TRIGGER, 14'd0);

        // Zero period: the second send may fall on the very same TTI.
        load_registers(1'b1, 64, 0, 0);
        push_event(srp_pkg::CMD_TRIGGER, 14'd0);
        push_event(srp_pkg::CMD_STEP, 14'd7);
        push_event(srp_pkg::CMD_STEP, 14'd7);

        // Disabling the resource while a request is pending fails it at the
        // next step.
        load_registers(1'b0, 64, 0, 0);
        push_event(srp_pkg::CMD_STEP, 14'd8);

        // Random phases, the extremes first. Grants are rare in the first so
        // that the attempt count climbs all the way to its maximum.
        load_registers(1'b1, 64, 0, 0);
        run_phase(130, 1);
        load_registers(1'b1, 1, 255, 1023);
        run_phase(130, 5);
        load_registers(1'b0, $urandom_range(0, 64), $urandom_range(0, 255),
                       $urandom_range(0, 1023));
        run_phase(30, 5);
        load_registers(1'b1, 0, $urandom_range(0, 255), $urandom_range(0, 1023));
        run_phase(30, 5);
        for (int p = 0; p < 5; p++)
        begin
            load_registers(1'b1, $urandom_range(1, 8), $urandom_range(0, 12),
                           $urandom_range(0, 4));
            run_phase(130, $urandom_range(1, 8));
        end

        // Final phase at full rate on both sides.
        load_registers(1'b1, $urandom_range(1, 8), $urandom_range(0, 12),
                       $urandom_range(0, 4));
        quiet_tail <= 1'b1;
        run_phase(130, 4);

        drain();
        repeat (5) @(posedge clk);
        if (sb.mismatches == 0 && sb.outcomes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
